/* rtl/tmx_pkg.sv */
// ----------------------------------------------------------------------------
// tmx_pkg
// Shared types and command codes for the 4x4 transform matrix unit.
// ----------------------------------------------------------------------------
package tmx_pkg;

  typedef enum logic [2:0] {
    CmdIdentity = 3'd0,
    CmdZero     = 3'd1,
    CmdTranslate = 3'd2,
    CmdScale    = 3'd3,
    CmdOrtho    = 3'd4,
    CmdLoadRow  = 3'd5,
    CmdMultiply = 3'd6,
    CmdRead     = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         row_select;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic signed [31:0] value_e;
    logic signed [31:0] value_f;
  } cmd_t;

  localparam int unsigned CmdWidth = $bits(cmd_t);

endpackage

/* rtl/tmx_fifo.sv */
// ----------------------------------------------------------------------------
// tmx_fifo
// Two-entry command queue between the intake stage and the execute engine.
// ----------------------------------------------------------------------------
module tmx_fifo import tmx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* rtl/tmx_div.sv */
// ----------------------------------------------------------------------------
// tmx_div
// Radix-2 signed divider, quotient truncated toward zero and saturated to 32.
// ----------------------------------------------------------------------------
module tmx_div #(
  parameter int unsigned NumWidth = 66
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [NumWidth-1:0] num_i,
  input  logic signed [32:0]         den_i,
  output logic                       done_o,
  output logic signed [31:0]         quot_o
);

  localparam int unsigned CntW = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] rem_q, quo_q;
  logic [32:0]         den_q;
  logic                neg_q, busy_q;
  logic [CntW-1:0]     cnt_q;
  logic [NumWidth-1:0] trial;
  logic [NumWidth-1:0] qs;

  assign trial = {rem_q[NumWidth-2:0], quo_q[NumWidth-1]};
  assign qs    = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_comb begin
    if (!neg_q && (quo_q > NumWidth'(32'h7fffffff))) quot_o = 32'sh7fffffff;
    else if (neg_q && (quo_q > NumWidth'(33'h080000000))) quot_o = 32'sh80000000;
    else quot_o = qs[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumWidth);
        rem_q  <= '0;
        quo_q  <= num_i[NumWidth-1] ? NumWidth'(-num_i) : NumWidth'(num_i);
        den_q  <= den_i[32] ? 33'(-den_i) : 33'(den_i);
        neg_q  <= num_i[NumWidth-1] ^ den_i[32];
      end else if (busy_q) begin
        // shift one quotient bit per cycle
        if (trial >= NumWidth'(den_q)) begin
          rem_q <= trial - NumWidth'(den_q);
          quo_q <= {quo_q[NumWidth-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[NumWidth-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/tmx_engine.sv */
// ----------------------------------------------------------------------------
// tmx_engine
// Execute engine: builds the right-hand matrix, runs the 4x4 product one
// multiply at a time, and emits status or read-out transactions.
// ----------------------------------------------------------------------------
module tmx_engine import tmx_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] entry_value_o,
  output logic [3:0]         entry_index_o,
  output logic               last_o,
  output logic               error_o
);

  localparam logic signed [31:0] One = 32'sd1 <<< FRACTION_BITS;
  localparam int unsigned NumW = 34 + FRACTION_BITS;
  // four shifted 64-bit products summed exactly
  localparam int unsigned AccW = 66 - FRACTION_BITS;
  localparam logic signed [AccW-1:0] AccMax = AccW'(64'sh7fffffff);
  localparam logic signed [AccW-1:0] AccMin = AccW'(-64'sh80000000);

  localparam logic [2:0] SIdle = 3'd0, SDiv = 3'd1, SMul = 3'd2, SAcc = 3'd3,
                         SCopy = 3'd4, SOut = 3'd5, SRead = 3'd6;

  logic [2:0] st_q;
  logic signed [31:0] cur_q [16];
  logic signed [31:0] opm_q [16];
  logic signed [31:0] rhs_q [16];
  logic signed [31:0] res_q [16];
  cmd_t cmd_q;
  logic [2:0] dstep_q;
  logic [5:0] mi_q;
  logic signed [63:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic       pv_q;
  logic [3:0] pidx_q;
  logic       plast_q;

  logic signed [32:0] dx, dy, dz;
  logic signed [NumW-1:0] dnum;
  logic signed [32:0] dden;
  logic dstart, ddone;
  logic signed [31:0] dquot;
  logic [3:0] r_i, k_i, c_i;
  logic signed [AccW-1:0] term, accn;

  assign dx = 33'(cmd_q.value_b) - 33'(cmd_q.value_a);
  assign dy = 33'(cmd_q.value_d) - 33'(cmd_q.value_c);
  assign dz = 33'(cmd_q.value_f) - 33'(cmd_q.value_e);

  // ortho quotients in order: [0],[5],[10],[12],[13],[14]
  always_comb begin
    unique case (dstep_q)
      3'd0: begin dnum = NumW'(2) <<< (2*FRACTION_BITS); dden = dx; end
      3'd1: begin dnum = NumW'(2) <<< (2*FRACTION_BITS); dden = dy; end
      3'd2: begin dnum = -(NumW'(2) <<< (2*FRACTION_BITS)); dden = dz; end
      3'd3: begin dnum = -(NumW'(33'(cmd_q.value_b) + 33'(cmd_q.value_a))) <<< FRACTION_BITS;
                  dden = dx; end
      3'd4: begin dnum = -(NumW'(33'(cmd_q.value_d) + 33'(cmd_q.value_c))) <<< FRACTION_BITS;
                  dden = dy; end
      default: begin
        dnum = -(NumW'(33'(cmd_q.value_f) + 33'(cmd_q.value_e))) <<< FRACTION_BITS;
        dden = dz;
      end
    endcase
  end

  tmx_div #(.NumWidth(NumW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quot_o(dquot)
  );

  // mi_q = r*16 + c*4 + k
  assign r_i  = {2'b00, mi_q[5:4]};
  assign c_i  = {2'b00, mi_q[3:2]};
  assign k_i  = {2'b00, mi_q[1:0]};
  assign term = AccW'(prod_q >>> FRACTION_BITS);
  assign accn = acc_q + term;

  assign cmd_pop_o = (st_q == SIdle) && cmd_valid_i && !pv_q;
  assign out_valid_o   = pv_q;
  assign entry_index_o = pidx_q;
  assign last_o        = plast_q;
  assign entry_value_o = (st_q == SRead || plast_q && pidx_q == 4'd15 && !error_o)
                         ? cur_q[pidx_q] : 32'sd0;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      dstep_q <= '0;
      mi_q    <= '0;
      prod_q  <= '0;
      acc_q   <= '0;
      pv_q    <= 1'b0;
      pidx_q  <= '0;
      plast_q <= 1'b0;
      error_o <= 1'b0;
      dstart  <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cur_q[i] <= (i % 5 == 0) ? One : 32'sd0;
        opm_q[i] <= 32'sd0;
        rhs_q[i] <= 32'sd0;
        res_q[i] <= 32'sd0;
      end
    end else begin
      dstart <= 1'b0;
      if (pv_q && !out_stall_i) pv_q <= 1'b0;
      unique case (st_q)
        SIdle: if (cmd_pop_o) begin
          pidx_q <= '0; error_o <= 1'b0; plast_q <= 1'b1;
          for (int i = 0; i < 16; i++) rhs_q[i] <= (i % 5 == 0) ? One : 32'sd0;
          mi_q <= '0; acc_q <= '0;
          unique case (cmd_e'(cmd_i.command))
            CmdIdentity: begin
              for (int i = 0; i < 16; i++) cur_q[i] <= (i % 5 == 0) ? One : 32'sd0;
              pv_q <= 1'b1;
            end
            CmdZero: begin
              for (int i = 0; i < 16; i++) cur_q[i] <= 32'sd0;
              pv_q <= 1'b1;
            end
            CmdTranslate: begin
              rhs_q[12] <= cmd_i.value_a; rhs_q[13] <= cmd_i.value_b;
              rhs_q[14] <= cmd_i.value_c; st_q <= SMul;
            end
            CmdScale: begin
              rhs_q[0] <= cmd_i.value_a; rhs_q[5] <= cmd_i.value_b;
              rhs_q[10] <= cmd_i.value_c; st_q <= SMul;
            end
            CmdOrtho: st_q <= SDiv;
            CmdLoadRow: begin
              opm_q[{cmd_i.row_select, 2'd0}] <= cmd_i.value_a;
              opm_q[{cmd_i.row_select, 2'd1}] <= cmd_i.value_b;
              opm_q[{cmd_i.row_select, 2'd2}] <= cmd_i.value_c;
              opm_q[{cmd_i.row_select, 2'd3}] <= cmd_i.value_d;
              pv_q <= 1'b1;
            end
            CmdMultiply: begin
              for (int i = 0; i < 16; i++) rhs_q[i] <= opm_q[i];
              st_q <= SMul;
            end
            default: begin
              plast_q <= 1'b0; pv_q <= 1'b1; st_q <= SRead;
            end
          endcase
          if (cmd_e'(cmd_i.command) == CmdOrtho) begin
            dstep_q <= '0;
            dstart  <= 1'b0;
          end
        end
        SDiv: begin
          if (dx == 33'sd0 || dy == 33'sd0 || dz == 33'sd0) begin
            error_o <= 1'b1; pv_q <= 1'b1; st_q <= SIdle;
          end else if (dstep_q == 3'd0 && !dstart && !ddone && mi_q == 6'd0) begin
            dstart <= 1'b1; mi_q <= 6'd1;
          end else if (ddone) begin
            unique case (dstep_q)
              3'd0: rhs_q[0] <= dquot;
              3'd1: rhs_q[5] <= dquot;
              3'd2: rhs_q[10] <= dquot;
              3'd3: rhs_q[12] <= dquot;
              3'd4: rhs_q[13] <= dquot;
              default: rhs_q[14] <= dquot;
            endcase
            if (dstep_q == 3'd5) begin
              st_q <= SMul; mi_q <= '0;
            end else begin
              dstep_q <= dstep_q + 3'd1; dstart <= 1'b1;
            end
          end
        end
        SMul: begin
          prod_q <= 64'(cur_q[{r_i[1:0], k_i[1:0]}]) * 64'(rhs_q[{k_i[1:0], c_i[1:0]}]);
          st_q <= SAcc;
        end
        SAcc: begin
          if (mi_q[1:0] == 2'd3) begin
            if (accn > AccMax) res_q[mi_q[5:2]] <= 32'sh7fffffff;
            else if (accn < AccMin) res_q[mi_q[5:2]] <= 32'sh80000000;
            else res_q[mi_q[5:2]] <= accn[31:0];
            acc_q <= '0;
          end else begin
            acc_q <= accn;
          end
          mi_q <= mi_q + 6'd1;
          st_q <= (mi_q == 6'd63) ? SCopy : SMul;
        end
        SCopy: begin
          for (int i = 0; i < 16; i++) cur_q[i] <= res_q[i];
          pv_q <= 1'b1; st_q <= SIdle;
        end
        SRead: if (!out_stall_i) begin
          if (pidx_q == 4'd15) begin
            pv_q <= 1'b0; plast_q <= 1'b0; pidx_q <= '0; st_q <= SIdle;
          end else begin
            pidx_q  <= pidx_q + 4'd1;
            plast_q <= pidx_q == 4'd14;
            pv_q    <= 1'b1;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

endmodule

/* rtl/transform_matrix_4x4_unit_top.sv */
// ----------------------------------------------------------------------------
// transform_matrix_4x4_unit_top
// 4x4 fixed-point transform matrix unit with a queued command front end.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and the execute engine works one at a
// time. Identity, zero and row load raise their status transaction from the
// idle state. A post-multiply runs 64 multiply-accumulate steps through one
// 32x32 multiplier, each step through SMul then SAcc. Ortho adds six radix-2
// divisions before the product. Read streams 16 entries, one per cycle
// without stall.
module transform_matrix_4x4_unit_top import tmx_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [1:0]         row_select_i,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic signed [31:0] value_c_i,
  input  logic signed [31:0] value_d_i,
  input  logic signed [31:0] value_e_i,
  input  logic signed [31:0] value_f_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] entry_value_o,
  output logic [3:0]         entry_index_o,
  output logic               last_o,
  output logic               error_o
);

  cmd_t in_cmd, q_cmd;
  logic full, empty, pop;

  assign in_cmd = '{command_i, row_select_i, value_a_i, value_b_i, value_c_i,
                    value_d_i, value_e_i, value_f_i};
  assign in_stall_o = full;

  tmx_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(in_valid_i && !full), .push_data_i(in_cmd),
    .full_o(full), .pop_i(pop), .empty_o(empty), .pop_data_o(q_cmd)
  );

  tmx_engine #(.FRACTION_BITS(FRACTION_BITS)) u_eng (
    .clk_i, .rst_ni, .cmd_valid_i(!empty), .cmd_i(q_cmd), .cmd_pop_o(pop),
    .out_valid_o, .out_stall_i, .entry_value_o, .entry_index_o, .last_o, .error_o
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> last_o) else $error("error without last");
  a_err_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (entry_index_o == 4'd0))
    else $error("error on read entry");

endmodule
